### hw/rtl/bra_pkg.sv
package bra_pkg;

    localparam int MAX_ITEMS  = 1024;
    localparam int WORD_BITS  = 64;
    localparam int MAP_WORDS  = (MAX_ITEMS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIDX_W     = $clog2(WORD_BITS);
    localparam int IDX_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int POP_W      = $clog2(WORD_BITS + 1);
    localparam int GROUPS     = WORD_BITS / 8;

    localparam int VAL_W      = 64;
    localparam int SIZE_W     = 32;
    localparam int LEN_W      = 11;
    localparam int ICNT_W     = 11;
    localparam int SUM_W      = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam int PROD_W     = CNT_W + SIZE_W;
    localparam int DCNT_W     = $clog2(VAL_W);
    localparam int IN_DATA_W  = ((LEN_W + VAL_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_VALUE = 2'd0,
        CFG_ITEM_SIZE  = 2'd1,
        CFG_ITEM_COUNT = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    // Bits of map word w whose item position lies in [lo, hi).
    function automatic logic [WORD_BITS-1:0] range_mask(
        input logic [WIDX_W-1:0] w,
        input logic [CNT_W-1:0]  lo,
        input logic [CNT_W-1:0]  hi
    );
        logic [WORD_BITS-1:0] m;
        logic [CNT_W-1:0]     pos;
        m = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            pos  = CNT_W'({w, BIDX_W'(j)});
            m[j] = (pos >= lo) && (pos < hi);
        end
        return m;
    endfunction

    function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
        logic [3:0]       part [GROUPS];
        logic [POP_W-1:0] total;
        total = '0;
        for (int g = 0; g < GROUPS; g++) begin
            part[g] = '0;
            for (int b = 0; b < 8; b++) begin
                part[g] = part[g] + 4'(v[g*8+b]);
            end
        end
        for (int g = 0; g < GROUPS; g++) begin
            total = total + POP_W'(part[g]);
        end
        return total;
    endfunction

endpackage

### hw/rtl/bitmap_range_allocator.sv
// Allocate: a count sweep over the 16 map words, a check, a mark sweep over the 16 words, the
// output load. Free: a bit-serial divide over 64 quotient bits, a setup step, a clear sweep over
// the 16 words, the output load. Zero-length requests and allocates with an item count of zero
// go straight to the load; an allocate short of free items or a free past the map skips marking.
// A new request can be accepted in the cycle after its result is registered; a stalled output delays that.
// Reset (synchronous, active low) clears the map at once and sets base 0, size 1, count 0.
module bitmap_range_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bra_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bra_pkg::VAL_W-1:0]       i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // run_length [10:0], start_value [74:11], zero fill [79:75]
    input  logic [bra_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // operation [0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // address [63:0]
    output logic [bra_pkg::VAL_W-1:0]       m_axis_tdata,
    // ok [0]
    output logic                            m_axis_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_CHECK,
        ST_DIVIDE,
        ST_SETUP,
        ST_MARK,
        ST_DONE
    } t_state;

    t_state                          r_state;
    logic [bra_pkg::VAL_W-1:0]       r_base;
    logic [bra_pkg::SIZE_W-1:0]      r_size;
    logic [bra_pkg::ICNT_W-1:0]      r_count;
    logic [bra_pkg::WORD_BITS-1:0]   r_map [bra_pkg::MAP_WORDS];

    bra_pkg::t_op                    r_op;
    logic [bra_pkg::LEN_W-1:0]       r_len;
    logic [bra_pkg::CNT_W-1:0]       r_used;
    logic [bra_pkg::CNT_W-1:0]       r_lo;
    logic [bra_pkg::CNT_W-1:0]       r_hi;
    logic [bra_pkg::WIDX_W-1:0]      r_word;
    logic [bra_pkg::VAL_W-1:0]       r_quo;
    logic [bra_pkg::SIZE_W-1:0]      r_rem;
    logic [bra_pkg::DCNT_W-1:0]      r_dcnt;
    logic [bra_pkg::PROD_W-1:0]      r_prod;
    logic                            r_ok;
    logic [bra_pkg::VAL_W-1:0]       r_addr;
    logic                            r_out_vld;
    logic                            r_out_ok;
    logic [bra_pkg::VAL_W-1:0]       r_out_addr;

    logic [bra_pkg::SIZE_W-1:0]      eff_size;
    logic [bra_pkg::CNT_W-1:0]       n_items;
    logic [bra_pkg::WORD_BITS-1:0]   word_mask;
    logic [bra_pkg::WORD_BITS-1:0]   cur_word;
    logic [bra_pkg::SIZE_W+1:0]      trial;
    logic [bra_pkg::SUM_W-1:0]       free_end;
    logic [bra_pkg::SUM_W-1:0]       alloc_end;
    logic                            accept;
    logic                            out_free;
    bra_pkg::t_op                    in_op;
    logic [bra_pkg::LEN_W-1:0]       in_len;
    logic [bra_pkg::VAL_W-1:0]       in_start;
    logic [bra_pkg::WORD_BITS-1:0]   n_word;

    assign in_op    = bra_pkg::t_op'(s_axis_tuser);
    assign in_len   = s_axis_tdata[bra_pkg::LEN_W-1:0];
    assign in_start = s_axis_tdata[bra_pkg::LEN_W +: bra_pkg::VAL_W];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = r_out_ok;

    assign eff_size = (r_size == '0) ? bra_pkg::SIZE_W'(1) : r_size;
    assign n_items  = (r_count > bra_pkg::ICNT_W'(bra_pkg::MAX_ITEMS))
                    ? bra_pkg::CNT_W'(bra_pkg::MAX_ITEMS) : bra_pkg::CNT_W'(r_count);

    // Shared per-word unit: range mask, used in both the count and the mark sweeps.
    assign cur_word  = r_map[r_word];
    assign word_mask = bra_pkg::range_mask(r_word, r_lo, r_hi);
    assign n_word    = (r_op == bra_pkg::OP_ALLOC) ? (cur_word | word_mask)
                                                   : (cur_word & ~word_mask);

    assign trial     = {1'b0, r_rem, r_quo[bra_pkg::VAL_W-1]} - {2'b00, eff_size};
    assign free_end  = bra_pkg::SUM_W'(r_quo[bra_pkg::IDX_W-1:0]) + bra_pkg::SUM_W'(r_len);
    assign alloc_end = bra_pkg::SUM_W'(r_used) + bra_pkg::SUM_W'(r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < bra_pkg::MAP_WORDS; w++) begin
                r_map[w] <= '0;
            end
        end else if (r_state == ST_MARK) begin
            r_map[r_word] <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_base    <= '0;
            r_size    <= bra_pkg::SIZE_W'(1);
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (bra_pkg::t_cfg_idx'(i_cfg_index))
                    bra_pkg::CFG_BASE_VALUE: r_base  <= i_cfg_data;
                    bra_pkg::CFG_ITEM_SIZE:  r_size  <= i_cfg_data[bra_pkg::SIZE_W-1:0];
                    bra_pkg::CFG_ITEM_COUNT: r_count <= i_cfg_data[bra_pkg::ICNT_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_vld && m_axis_tready && (r_state != ST_DONE)) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_op   <= in_op;
                        r_len  <= in_len;
                        r_word <= '0;
                        r_ok   <= 1'b0;
                        r_addr <= '0;
                        if (in_op == bra_pkg::OP_ALLOC) begin
                            if (n_items == '0) begin
                                r_state <= ST_DONE;
                            end else if (in_len == '0) begin
                                r_ok    <= 1'b1;
                                r_addr  <= r_base;
                                r_state <= ST_DONE;
                            end else begin
                                r_lo    <= '0;
                                r_hi    <= n_items;
                                r_used  <= '0;
                                r_state <= ST_COUNT;
                            end
                        end else begin
                            if (in_len == '0) begin
                                r_state <= ST_DONE;
                            end else begin
                                r_quo   <= in_start - r_base;
                                r_rem   <= '0;
                                r_dcnt  <= '0;
                                r_state <= ST_DIVIDE;
                            end
                        end
                    end
                end
                ST_COUNT: begin
                    r_used <= r_used + bra_pkg::CNT_W'(bra_pkg::popcount(cur_word & word_mask));
                    r_word <= r_word + 1'b1;
                    if (r_word == bra_pkg::WIDX_W'(bra_pkg::MAP_WORDS - 1)) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (bra_pkg::SUM_W'(n_items - r_used) >= bra_pkg::SUM_W'(r_len)) begin
                        r_lo    <= r_used;
                        r_hi    <= bra_pkg::CNT_W'(alloc_end);
                        r_prod  <= bra_pkg::PROD_W'(r_used) * bra_pkg::PROD_W'(eff_size);
                        r_word  <= '0;
                        r_state <= ST_MARK;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DIVIDE: begin
                    if (!trial[bra_pkg::SIZE_W+1]) begin
                        r_rem <= trial[bra_pkg::SIZE_W-1:0];
                        r_quo <= {r_quo[bra_pkg::VAL_W-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[bra_pkg::SIZE_W-2:0], r_quo[bra_pkg::VAL_W-1]};
                        r_quo <= {r_quo[bra_pkg::VAL_W-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == bra_pkg::DCNT_W'(bra_pkg::VAL_W - 1)) begin
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_ok <= 1'b1;
                    if (r_quo[bra_pkg::VAL_W-1:bra_pkg::IDX_W] != '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_lo <= bra_pkg::CNT_W'(r_quo[bra_pkg::IDX_W-1:0]);
                        r_hi <= (free_end > bra_pkg::SUM_W'(bra_pkg::MAX_ITEMS))
                              ? bra_pkg::CNT_W'(bra_pkg::MAX_ITEMS)
                              : bra_pkg::CNT_W'(free_end);
                        r_word  <= '0;
                        r_state <= ST_MARK;
                    end
                end
                ST_MARK: begin
                    r_word <= r_word + 1'b1;
                    if (r_word == bra_pkg::WIDX_W'(bra_pkg::MAP_WORDS - 1)) begin
                        if (r_op == bra_pkg::OP_ALLOC) begin
                            r_ok   <= 1'b1;
                            r_addr <= r_base + bra_pkg::VAL_W'(r_prod);
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_ok   <= r_ok;
                        r_out_addr <= r_addr;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("block still ready after accepting a word");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && !r_ok |-> (r_addr == '0))
        else $error("failed request carries a nonzero address");

    a_mark_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MARK) |-> (r_lo <= r_hi) &&
                                 (r_hi <= bra_pkg::CNT_W'(bra_pkg::MAX_ITEMS)))
        else $error("mark range outside the map");

    a_alloc_within_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MARK) && (r_op == bra_pkg::OP_ALLOC) |-> (r_hi <= n_items))
        else $error("allocation runs past the item count");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && !out_free |=> (r_state == ST_DONE) && $stable(r_addr))
        else $error("pending result lost while output stalled");

endmodule
